/* sv/per_id_fixed_window_rate_limiter_macros.svh */
// assertion macros for the rate limiter module
`ifndef PER_ID_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_ID_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH

// same-cycle implication, checked outside reset
`define FWRL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FWRL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fwrl_pkg.sv */
package fwrl_pkg;

    // request opcodes
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_INIT  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PACKETS = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MS   = 8'd1;

    // register reset values
    localparam logic [15:0] MAX_PACKETS_RESET = 16'd200;
    localparam logic [31:0] WINDOW_MS_RESET   = 32'd1000;

    // saturation point of the packet count
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // one table entry as held in memory
    typedef struct packed {
        logic        configured;
        logic [15:0] packet_count;
        logic [31:0] window_start;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

endpackage

/* sv/fwrl_ram.sv */
module fwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/fwrl_update.sv */
module fwrl_update (
    input  fwrl_pkg::entry_t rd_entry,
    input  logic             op,
    input  logic [31:0]      now_ms,
    input  logic [31:0]      window_ms,
    input  logic [15:0]      max_packets,
    output fwrl_pkg::entry_t wr_entry,
    output logic             allowed
);

    logic [31:0] elapsed;
    logic        expired;
    logic        count_sat;
    logic [15:0] count_inc;
    logic        under_limit;

    // window age, modulo 2^32
    assign elapsed = now_ms - rd_entry.window_start;
    assign expired = (elapsed >= window_ms);

    // saturating count; the limit test looks at the count before the increment
    assign count_sat   = (rd_entry.packet_count == fwrl_pkg::COUNT_MAX);
    assign count_inc   = count_sat ? rd_entry.packet_count : rd_entry.packet_count + 16'd1;
    assign under_limit = (rd_entry.packet_count < max_packets)
                       || (count_sat && (max_packets == fwrl_pkg::COUNT_MAX));

    // new entry contents and verdict
    always_comb begin
        wr_entry = rd_entry;
        allowed  = 1'b0;
        if (op == fwrl_pkg::OP_INIT) begin
            wr_entry.configured   = 1'b1;
            wr_entry.packet_count = 16'd0;
            wr_entry.window_start = now_ms;
        end else if (!rd_entry.configured || expired) begin
            wr_entry.packet_count = 16'd1;
            wr_entry.window_start = now_ms;
            allowed               = 1'b1;
        end else begin
            wr_entry.packet_count = count_inc;
            allowed               = under_limit;
        end
    end

endmodule

/* sv/per_id_fixed_window_rate_limiter.sv */
// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   tdata: sender_id, now_ms; tuser: opcode
// m_        out  m_tvalid/m_tready   tdata: allowed
// cfg_      in   cfg_valid/cfg_ready cfg_addr: register index; cfg_data: value
//
// each item is accepted in idle, which reads its entry from the registered table memory;
// the update state then updates the entry, writes it back and loads the result. s_tready
// is low outside idle. after reset a clearing pass writes every entry, with s_tready low.
// a full result register with m_tready low holds the update cycle until it drains.
// cfg_ready is always high; register writes take effect in the following cycle.

`include "per_id_fixed_window_rate_limiter_macros.svh"

module per_id_fixed_window_rate_limiter #(
    parameter int ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] sender_id, [47:16] now_ms
    input  logic [0:0]  s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] allowed, [7:1] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [fwrl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0] cfg_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    fwrl_pkg::state_t state_reg, state_next;

    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [15:0]       max_packets_reg;
    logic [31:0]       window_ms_reg;
    logic              op_reg;
    logic [31:0]       now_reg;
    logic [AW-1:0]     id_reg;
    logic              hit_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              allowed_reg, allowed_next;

    logic              accept;
    logic              out_free;
    logic              clr_last;
    logic              id_in_range;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [fwrl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [fwrl_pkg::ENTRY_W-1:0] ram_rdata;
    fwrl_pkg::entry_t  rd_entry;
    fwrl_pkg::entry_t  wr_entry;
    logic              upd_allowed;

    // handshake terms
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign clr_last    = (clr_cnt_reg == AW'(ENTRIES - 1));
    assign id_in_range = ({1'b0, s_tdata[15:0]} < 17'(ENTRIES));
    assign cfg_ready   = 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fwrl_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = fwrl_pkg::ST_IDLE;
                end
            end
            fwrl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = fwrl_pkg::ST_UPDATE;
                end
            end
            fwrl_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = fwrl_pkg::ST_IDLE;
                end
            end
            default: state_next = fwrl_pkg::ST_CLEAR;
        endcase
    end

    // state outputs: memory write, input ready, clear counter
    always_comb begin
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = id_reg;
        ram_wdata    = wr_entry;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            fwrl_pkg::ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            fwrl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            fwrl_pkg::ST_UPDATE: begin
                ram_we = out_free && hit_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result register next value
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        allowed_next  = allowed_reg;
        if ((state_reg == fwrl_pkg::ST_UPDATE) && out_free) begin
            m_tvalid_next = 1'b1;
            allowed_next  = hit_reg && upd_allowed;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fwrl_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_packets_reg <= fwrl_pkg::MAX_PACKETS_RESET;
            window_ms_reg   <= fwrl_pkg::WINDOW_MS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                fwrl_pkg::REG_MAX_PACKETS: max_packets_reg <= cfg_data[15:0];
                fwrl_pkg::REG_WINDOW_MS:   window_ms_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser[0];
            now_reg <= s_tdata[47:16];
            id_reg  <= s_tdata[AW-1:0];
            hit_reg <= id_in_range;
        end
        allowed_reg <= allowed_next;
    end

    // entry table
    fwrl_ram #(
        .WIDTH (fwrl_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_tdata[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;

    // entry update
    fwrl_update u_update (
        .rd_entry    (rd_entry),
        .op          (op_reg),
        .now_ms      (now_reg),
        .window_ms   (window_ms_reg),
        .max_packets (max_packets_reg),
        .wr_entry    (wr_entry),
        .allowed     (upd_allowed)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, allowed_reg};

    // checks
    `FWRL_ASSERT_NOW(a_we_state, aclk, aresetn, ram_we, (state_reg == fwrl_pkg::ST_UPDATE) || (state_reg == fwrl_pkg::ST_CLEAR), "table written outside update or clear")
    `FWRL_ASSERT_NEXT(a_accept_update, aclk, aresetn, accept, state_reg == fwrl_pkg::ST_UPDATE, "accepted transfer did not move to update")
    `FWRL_ASSERT_NEXT(a_range_deny, aclk, aresetn, (state_reg == fwrl_pkg::ST_UPDATE) && out_free && !hit_reg, m_tvalid_reg && !allowed_reg, "out of range id not denied")
    `FWRL_ASSERT_NEXT(a_init_zero, aclk, aresetn, (state_reg == fwrl_pkg::ST_UPDATE) && out_free && (op_reg == fwrl_pkg::OP_INIT), m_tvalid_reg && !allowed_reg, "init result not zero")

endmodule
